// ----- rtl/arm_data_processing_alu_core_defines.svh -----
// Assertion macros shared by the ALU core RTL.
// Needs a clk and an active-low rst_n in the scope where it is used.
`ifndef ARM_DATA_PROCESSING_ALU_CORE_DEFINES_SVH
`define ARM_DATA_PROCESSING_ALU_CORE_DEFINES_SVH

// Checked property, off while reset is held.
`define ADPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, live during reset as well.
`define ADPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/adpa_pkg.sv -----
// Shared types and constants for the data-processing ALU core.
// No dependencies; imported by adpa_decode, the top level, the checker and the testbench.
package adpa_pkg;

  localparam int unsigned XLEN = 32;
  localparam logic [3:0]  PC_INDEX = 4'd15;

  typedef enum logic [3:0] {
    CMD_AND = 4'd0,
    CMD_EOR = 4'd1,
    CMD_SUB = 4'd2,
    CMD_RSB = 4'd3,
    CMD_ADD = 4'd4,
    CMD_ADC = 4'd5,
    CMD_SBC = 4'd6,
    CMD_RSC = 4'd7,
    CMD_TST = 4'd8,
    CMD_TEQ = 4'd9,
    CMD_CMP = 4'd10,
    CMD_CMN = 4'd11,
    CMD_ORR = 4'd12,
    CMD_MOV = 4'd13,
    CMD_BIC = 4'd14,
    CMD_MVN = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    CIN_ZERO = 2'd0,
    CIN_ONE  = 2'd1,
    CIN_FLAG = 2'd2
  } cin_sel_t;

  typedef enum logic [2:0] {
    LOG_AND = 3'd0,
    LOG_EOR = 3'd1,
    LOG_ORR = 3'd2,
    LOG_MOV = 3'd3,
    LOG_BIC = 3'd4,
    LOG_MVN = 3'd5
  } logic_sel_t;

  typedef struct packed {
    logic       arith;
    logic       swap;
    logic       inv_y;
    cin_sel_t   cin_sel;
    logic_sel_t logic_sel;
    logic       wb;
  } ctrl_t;

endpackage

// ----- rtl/arm_data_processing_alu_core.sv -----
// Data-processing ALU core, 32-bit, sixteen opcodes, stream in and stream out.
// Depends on adpa_pkg, adpa_decode and arm_data_processing_alu_core_defines.svh.
//
// Each word passes stages 1 to 3 in order: stage 1 decodes and selects adder
// operands and the logic result, stage 2 runs the 32-bit carry add and picks
// C and V, stage 3 forms N and Z, masks the flags and holds the output word.
// Sustained rate is one word per cycle while out_tready is high; each stage
// holds its word while the next stage is full and stalled; no word is lost or repeated.
`include "arm_data_processing_alu_core_defines.svh"

module arm_data_processing_alu_core
  import adpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] command, [35:4] operand_a, [67:36] operand_b, [71:68] dest_index,
  // [72] s_bit, [73] shifter_carry, [74] carry_in, [75] overflow_in, [79:76] zero
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] result_value, [32] reg_write, [33] flags_updated, [34] neg_flag,
  // [35] zero_flag, [36] carry_flag, [37] ovf_flag, [39:38] zero
  output logic [39:0] out_tdata
);

  cmd_t            in_cmd;
  logic [XLEN-1:0] in_a;
  logic [XLEN-1:0] in_b;
  logic [3:0]      in_dest;
  logic            in_s, in_shc, in_cin, in_vin;
  ctrl_t           dec;

  assign in_cmd  = cmd_t'(in_tdata[3:0]);
  assign in_a    = in_tdata[35:4];
  assign in_b    = in_tdata[67:36];
  assign in_dest = in_tdata[71:68];
  assign in_s    = in_tdata[72];
  assign in_shc  = in_tdata[73];
  assign in_cin  = in_tdata[74];
  assign in_vin  = in_tdata[75];

  adpa_decode u_decode (
    .cmd  (in_cmd),
    .ctrl (dec)
  );

  logic adv1, adv2, adv3;

  // stage 1 registers
  logic            s1_valid_r, s1_valid_nxt;
  logic [XLEN-1:0] s1_x_r, s1_x_nxt;
  logic [XLEN-1:0] s1_y_r, s1_y_nxt;
  logic            s1_c_r, s1_c_nxt;
  logic [XLEN-1:0] s1_log_r, s1_log_nxt;
  logic            s1_arith_r, s1_wb_r, s1_upd_r, s1_shc_r, s1_vin_r;
  logic            s1_upd_nxt;
  logic [3:0]      s1_dest_r;

  // stage 2 registers
  logic            s2_valid_r, s2_valid_nxt;
  logic [XLEN-1:0] s2_res_r, s2_res_nxt;
  logic            s2_c_r, s2_c_nxt;
  logic            s2_v_r, s2_v_nxt;
  logic            s2_wb_r, s2_upd_r;

  // stage 3 (output) registers
  logic            s3_valid_r, s3_valid_nxt;
  logic [XLEN-1:0] s3_res_r;
  logic            s3_wb_r, s3_upd_r, s3_n_r, s3_z_r, s3_c_r, s3_v_r;
  logic            s3_n_nxt, s3_z_nxt, s3_c_nxt, s3_v_nxt;

  assign adv3      = !s3_valid_r || out_tready;
  assign adv2      = !s2_valid_r || adv3;
  assign adv1      = !s1_valid_r || adv2;
  assign in_tready = adv1;

  // stage 1: operand select and logic result
  always_comb begin
    logic [XLEN-1:0] ysrc;
    ysrc     = dec.swap ? in_a : in_b;
    s1_x_nxt = dec.swap ? in_b : in_a;
    s1_y_nxt = dec.inv_y ? ~ysrc : ysrc;
    unique case (dec.cin_sel)
      CIN_ZERO: s1_c_nxt = 1'b0;
      CIN_ONE:  s1_c_nxt = 1'b1;
      CIN_FLAG: s1_c_nxt = in_cin;
      default:  s1_c_nxt = 1'b0;
    endcase
    unique case (dec.logic_sel)
      LOG_AND: s1_log_nxt = in_a & in_b;
      LOG_EOR: s1_log_nxt = in_a ^ in_b;
      LOG_ORR: s1_log_nxt = in_a | in_b;
      LOG_MOV: s1_log_nxt = in_b;
      LOG_BIC: s1_log_nxt = in_a & ~in_b;
      LOG_MVN: s1_log_nxt = ~in_b;
      default: s1_log_nxt = in_a & in_b;
    endcase
    s1_upd_nxt   = in_s && (in_dest != PC_INDEX);
    s1_valid_nxt = adv1 ? in_tvalid : s1_valid_r;
  end

  // stage 2: carry add, flag source select
  always_comb begin
    logic [XLEN:0] sum;
    sum = {1'b0, s1_x_r} + {1'b0, s1_y_r} + {{XLEN{1'b0}}, s1_c_r};
    if (s1_arith_r) begin
      s2_res_nxt = sum[XLEN-1:0];
      s2_c_nxt   = sum[XLEN];
      s2_v_nxt   = ~(s1_x_r[XLEN-1] ^ s1_y_r[XLEN-1]) & (s1_x_r[XLEN-1] ^ sum[XLEN-1]);
    end else begin
      s2_res_nxt = s1_log_r;
      s2_c_nxt   = s1_shc_r;
      s2_v_nxt   = s1_vin_r;
    end
    s2_valid_nxt = adv2 ? s1_valid_r : s2_valid_r;
  end

  // stage 3: N, Z and masking
  always_comb begin
    s3_n_nxt     = s2_upd_r & s2_res_r[XLEN-1];
    s3_z_nxt     = s2_upd_r & (s2_res_r == '0);
    s3_c_nxt     = s2_upd_r & s2_c_r;
    s3_v_nxt     = s2_upd_r & s2_v_r;
    s3_valid_nxt = adv3 ? s2_valid_r : s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_x_r     <= s1_x_nxt;
      s1_y_r     <= s1_y_nxt;
      s1_c_r     <= s1_c_nxt;
      s1_log_r   <= s1_log_nxt;
      s1_arith_r <= dec.arith;
      s1_wb_r    <= dec.wb;
      s1_upd_r   <= s1_upd_nxt;
      s1_shc_r   <= in_shc;
      s1_vin_r   <= in_vin;
      s1_dest_r  <= in_dest;
    end
    if (adv2) begin
      s2_res_r <= s2_res_nxt;
      s2_c_r   <= s2_c_nxt;
      s2_v_r   <= s2_v_nxt;
      s2_wb_r  <= s1_wb_r;
      s2_upd_r <= s1_upd_r;
    end
    if (adv3) begin
      s3_res_r <= s2_res_r;
      s3_wb_r  <= s2_wb_r;
      s3_upd_r <= s2_upd_r;
      s3_n_r   <= s3_n_nxt;
      s3_z_r   <= s3_z_nxt;
      s3_c_r   <= s3_c_nxt;
      s3_v_r   <= s3_v_nxt;
    end
  end

  assign out_tvalid = s3_valid_r;
  assign out_tdata  = {2'b00, s3_v_r, s3_c_r, s3_z_r, s3_n_r, s3_upd_r, s3_wb_r, s3_res_r};

  `ADPA_ASSERT(a_flags_masked,
    (s3_valid_r && !s3_upd_r) |-> !(s3_n_r || s3_z_r || s3_c_r || s3_v_r),
    "flag bits set on a word without flag update")
  `ADPA_ASSERT(a_pc_no_update,
    (s1_valid_r && s1_dest_r == PC_INDEX) |-> !s1_upd_r,
    "flag update enabled for a PC destination")
  `ADPA_ASSERT(a_out_hold,
    (s3_valid_r && !out_tready) |=> (s3_valid_r && $stable(s3_res_r) && $stable(s3_upd_r)),
    "output word changed while stalled")
  `ADPA_ASSERT(a_s2_hold,
    (s2_valid_r && !adv3) |=> (s2_valid_r && $stable(s2_res_r) && $stable(s2_c_r)),
    "stage 2 word changed while stalled")
  `ADPA_ASSERT_ALWAYS(a_reset_empty,
    !rst_n |=> !(s1_valid_r || s2_valid_r || s3_valid_r),
    "pipeline not empty after reset")

endmodule

// ----- rtl/adpa_decode.sv -----
// Opcode decoder: maps the 4-bit data-processing opcode to adder and logic controls.
// Depends on adpa_pkg.
module adpa_decode
  import adpa_pkg::*;
(
  input  cmd_t  cmd,
  output ctrl_t ctrl
);

  always_comb begin
    ctrl.arith     = 1'b0;
    ctrl.swap      = 1'b0;
    ctrl.inv_y     = 1'b0;
    ctrl.cin_sel   = CIN_ZERO;
    ctrl.logic_sel = LOG_AND;
    ctrl.wb        = 1'b1;
    unique case (cmd)
      CMD_AND: ctrl.logic_sel = LOG_AND;
      CMD_EOR: ctrl.logic_sel = LOG_EOR;
      CMD_SUB: begin
        ctrl.arith = 1'b1; ctrl.inv_y = 1'b1; ctrl.cin_sel = CIN_ONE;
      end
      CMD_RSB: begin
        ctrl.arith = 1'b1; ctrl.swap = 1'b1; ctrl.inv_y = 1'b1; ctrl.cin_sel = CIN_ONE;
      end
      CMD_ADD: ctrl.arith = 1'b1;
      CMD_ADC: begin
        ctrl.arith = 1'b1; ctrl.cin_sel = CIN_FLAG;
      end
      CMD_SBC: begin
        ctrl.arith = 1'b1; ctrl.inv_y = 1'b1; ctrl.cin_sel = CIN_FLAG;
      end
      CMD_RSC: begin
        ctrl.arith = 1'b1; ctrl.swap = 1'b1; ctrl.inv_y = 1'b1; ctrl.cin_sel = CIN_FLAG;
      end
      CMD_TST: begin
        ctrl.logic_sel = LOG_AND; ctrl.wb = 1'b0;
      end
      CMD_TEQ: begin
        ctrl.logic_sel = LOG_EOR; ctrl.wb = 1'b0;
      end
      CMD_CMP: begin
        ctrl.arith = 1'b1; ctrl.inv_y = 1'b1; ctrl.cin_sel = CIN_ONE; ctrl.wb = 1'b0;
      end
      CMD_CMN: begin
        ctrl.arith = 1'b1; ctrl.wb = 1'b0;
      end
      CMD_ORR: ctrl.logic_sel = LOG_ORR;
      CMD_MOV: ctrl.logic_sel = LOG_MOV;
      CMD_BIC: ctrl.logic_sel = LOG_BIC;
      CMD_MVN: ctrl.logic_sel = LOG_MVN;
    endcase
  end

endmodule

// ----- verif/alu_result_checker.sv -----
// Checker for arm_data_processing_alu_core: watches both stream channels,
// predicts each result word and compares it field by field against the core.
// Depends on adpa_pkg for the opcode enum and PC_INDEX.
module alu_result_checker
  import adpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          words_in,
  output int          words_out
);

  typedef struct packed {
    logic        v;
    logic        c;
    logic        z;
    logic        n;
    logic        upd;
    logic        wb;
    logic [31:0] value;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic alu_result_t compute_alu(logic [79:0] w);
    cmd_t        cmd;
    logic [31:0] a, b, x, y, r;
    logic [32:0] sum;
    logic [3:0]  dst;
    logic        s, shc, cin, vin, cadd, use_add, wb, cy, ov, upd;
    alu_result_t res;
    cmd = cmd_t'(w[3:0]);
    a = w[35:4];
    b = w[67:36];
    dst = w[71:68];
    s = w[72];
    shc = w[73];
    cin = w[74];
    vin = w[75];
    use_add = 1'b1;
    wb = 1'b1;
    x = a;
    y = b;
    cadd = 1'b0;
    r = '0;
    case (cmd)
      CMD_AND: begin r = a & b; use_add = 1'b0; end
      CMD_EOR: begin r = a ^ b; use_add = 1'b0; end
      CMD_SUB: begin y = ~b; cadd = 1'b1; end
      CMD_RSB: begin x = b; y = ~a; cadd = 1'b1; end
      CMD_ADD: ;
      CMD_ADC: cadd = cin;
      CMD_SBC: begin y = ~b; cadd = cin; end
      CMD_RSC: begin x = b; y = ~a; cadd = cin; end
      CMD_TST: begin r = a & b; use_add = 1'b0; wb = 1'b0; end
      CMD_TEQ: begin r = a ^ b; use_add = 1'b0; wb = 1'b0; end
      CMD_CMP: begin y = ~b; cadd = 1'b1; wb = 1'b0; end
      CMD_CMN: wb = 1'b0;
      CMD_ORR: begin r = a | b; use_add = 1'b0; end
      CMD_MOV: begin r = b; use_add = 1'b0; end
      CMD_BIC: begin r = a & ~b; use_add = 1'b0; end
      default: begin r = ~b; use_add = 1'b0; end
    endcase
    if (use_add) begin
      sum = {1'b0, x} + {1'b0, y} + {32'd0, cadd};
      r = sum[31:0];
      cy = sum[32];
      ov = (x[31] == y[31]) && (r[31] != x[31]);
    end else begin
      cy = shc;
      ov = vin;
    end
    upd = s && (dst != PC_INDEX);
    res.value = r;
    res.wb = wb;
    res.upd = upd;
    res.n = upd & r[31];
    res.z = upd & (r == 32'd0);
    res.c = upd & cy;
    res.v = upd & ov;
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    alu_result_t exp_res, act_res;
    if (!rst_n) begin
      expected_results.delete();
      pending = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(compute_alu(in_tdata));
        words_in++;
      end
      if (out_tvalid && out_tready) begin
        words_out++;
        act_res = out_tdata[37:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          report_field("result_value", exp_res.value, act_res.value);
          report_field("reg_write", 32'(exp_res.wb), 32'(act_res.wb));
          report_field("flags_updated", 32'(exp_res.upd), 32'(act_res.upd));
          report_field("neg_flag", 32'(exp_res.n), 32'(act_res.n));
          report_field("zero_flag", 32'(exp_res.z), 32'(act_res.z));
          report_field("carry_flag", 32'(exp_res.c), 32'(act_res.c));
          report_field("ovf_flag", 32'(exp_res.v), 32'(act_res.v));
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the ALU core testbench: clock, reset, directed and random stimulus, output stalls.
// Depends on adpa_pkg, arm_data_processing_alu_core and alu_result_checker.
module testbench;
  import adpa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  int          words_in;
  int          words_out;
  bit          in_gaps;
  bit          out_stalls;
  int          ready_hold;

  arm_data_processing_alu_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  alu_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending),
    .words_in  (words_in),
    .words_out (words_out)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly short idle spans, now and then a long one.
  function automatic int idle_span(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [79:0] make_word(cmd_t cmd, logic [31:0] a, logic [31:0] b,
                                            logic [3:0] dst, logic s, logic shc,
                                            logic cin, logic vin);
    return {4'd0, vin, cin, shc, s, dst, b, a, cmd};
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_word(logic [79:0] w);
    int gap;
    gap = idle_span(in_gaps);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = w;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
      ready_hold = 0;
    end else if (!out_stalls) begin
      out_tready = 1'b1;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      out_tready = ($urandom_range(0, 3) != 0);
      ready_hold = out_tready ? $urandom_range(0, 6) : idle_span(1'b1);
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d result words outstanding", $time, pending);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_gaps = 1'b1;
    out_stalls = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every opcode, mostly at the operand extremes, flag corner cases
    send_word(make_word(CMD_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b1, 1'b0, 1'b1));
    send_word(make_word(CMD_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1, 1'b1, 1'b0, 1'b1, 1'b0));
    send_word(make_word(CMD_SUB, 32'h0000_0000, 32'h0000_0001, 4'd2, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(make_word(CMD_RSB, 32'h0000_0001, 32'h8000_0000, 4'd3, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 4'd4, 1'b1, 1'b0, 1'b0, 1'b1));
    send_word(make_word(CMD_ADC, 32'h7FFF_FFFF, 32'h0000_0000, 4'd5, 1'b1, 1'b0, 1'b1, 1'b0));
    send_word(make_word(CMD_SBC, 32'h0000_0000, 32'h0000_0000, 4'd6, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(make_word(CMD_RSC, 32'h0000_0000, 32'hFFFF_FFFF, 4'd7, 1'b1, 1'b0, 1'b1, 1'b1));
    send_word(make_word(CMD_TST, 32'hAAAA_AAAA, 32'h5555_5555, 4'd8, 1'b1, 1'b1, 1'b0, 1'b1));
    send_word(make_word(CMD_TEQ, 32'h8000_0000, 32'h0000_0000, 4'd9, 1'b1, 1'b0, 1'b1, 1'b1));
    send_word(make_word(CMD_CMP, 32'h1234_5678, 32'h1234_5678, 4'd10, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(make_word(CMD_CMN, 32'h8000_0000, 32'h8000_0000, 4'd11, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(make_word(CMD_ORR, 32'h0000_0000, 32'h0000_0000, 4'd12, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(make_word(CMD_MOV, 32'hFFFF_FFFF, 32'h0000_0000, 4'd13, 1'b1, 1'b0, 1'b0, 1'b1));
    send_word(make_word(CMD_BIC, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 4'd14, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(make_word(CMD_MVN, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    // destination is the PC: no flag update even with S set
    send_word(make_word(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PC_INDEX, 1'b1, 1'b1, 1'b1,
                        1'b1));
    send_word(make_word(CMD_CMP, 32'h0000_0000, 32'h0000_0001, PC_INDEX, 1'b1, 1'b1, 1'b1,
                        1'b1));
    // S clear on the first and last word here, so their flag outputs stay low; the rest set S
    send_word(make_word(CMD_SUB, 32'h8000_0000, 32'h0000_0001, 4'd3, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(make_word(CMD_CMP, 32'h8000_0000, 32'h0000_0001, 4'd7, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(make_word(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 4'd11, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(make_word(CMD_SBC, 32'h8000_0000, 32'h0000_0000, 4'd5, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(make_word(CMD_MVN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b1, 1'b1, 1'b1));

    for (int i = 0; i < 450; i++) begin
      if (i % 50 == 0) begin
        in_gaps = ($urandom_range(0, 3) != 0);
        out_stalls = ($urandom_range(0, 3) != 0);
      end
      send_word(make_word(cmd_t'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                          4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom)));
    end
    in_tvalid = 1'b0;
    out_stalls = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d words covering all sixteen opcodes, PC destination and S-clear cases,",
             words_in);
    $display("plus random operands under input gaps and output stalls; %0d results compared.",
             words_out);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/adpa_pkg.sv
rtl/adpa_decode.sv
rtl/arm_data_processing_alu_core.sv
verif/alu_result_checker.sv
verif/testbench.sv
